// File: design/route_update_coalescing_queue_defines.svh
// Assertion macros used by the checker in rucq_checker.sv.
`ifndef ROUTE_UPDATE_COALESCING_QUEUE_DEFINES_SVH
`define ROUTE_UPDATE_COALESCING_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RUCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RUCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rucq_pkg.sv
`default_nettype none
package rucq_pkg;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_DEL,
    REQ_REPLACE,
    REQ_PUSH
  } req_t;

  typedef enum logic [1:0] {
    OP_ANNOUNCE,
    OP_WITHDRAW,
    OP_REPLACE,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ADD_DUP,
    ST_DEL_DUP,
    ST_FULL
  } st_t;

  // Kind of a queued entry; a replace holds an old half then a new half
  typedef enum logic [1:0] {
    K_ADD,
    K_DEL,
    K_OLD,
    K_NEW
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_COMPACT,
    S_APPEND,
    S_PUSH_CHK,
    S_DRAIN,
    S_DR_END
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] prefix_addr;
    logic [5:0]  prefix_len;
    logic [15:0] route_id;
    logic [15:0] attr_id;
    logic        from_ibgp;
    logic [15:0] old_route_id;
    logic [15:0] old_attr_id;
    logic        old_from_ibgp;
    logic        push_after;
  } in_item_t;

  typedef struct packed {
    op_t         op_kind;
    st_t         status;
    logic [31:0] out_prefix_addr;
    logic [5:0]  out_prefix_len;
    logic [15:0] out_route_id;
    logic        out_ibgp;
    logic [15:0] out_old_route_id;
    logic        out_old_ibgp;
    logic [15:0] group_attr_id;
    logic        packet_last;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/rucq_ram.sv
`default_nettype none
module rucq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: design/route_update_coalescing_queue.sv
`default_nettype none
// Route-update coalescing queue.
// Input: an item is taken on a rising edge with start high and busy low; busy
// stays high until all work for that item is done. Result items appear on
// out_item for one cycle with out_valid high; the receiver cannot hold them off.
// Each add, delete or replace request first scans the queue for its prefix
// through the single read port of the entry memory, then removes entries by an
// in-place compaction scan where the merge needs it, and appends up to two
// entries, one at a time. An error gives one status result and leaves the queue
// untouched. A push drains the queue packet by packet: each packet is one scan
// of the remaining entries, giving at most one result per cycle; the last
// result of a packet has packet_last set and the last result of the request has
// last set. Busy covers the search, any compaction and the appends, and each
// drain pass adds its own scan. The memory read port paces every scan. Reset
// empties the queue (the count goes to zero, the memory is not cleared) and
// drops any item in progress.
module route_update_coalescing_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rucq_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 out_valid,
  output rucq_pkg::out_item_t  out_item
);
  import rucq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] NEAR_C = CW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [37:0]            key;
    logic [15:0]            attr;
    logic [HANDLE_BITS-1:0] hdl;
    logic                   ibgp;
    kind_t                  kind;
  } ent_t;

  localparam int EW = $bits(ent_t);

  // Build one update result from an entry (and the old half of a replace)
  function automatic out_item_t mk_upd(op_t op, ent_t e, ent_t o, logic use_old,
                                       logic [15:0] ga);
    out_item_t   r;
    logic [47:0] hx;
    logic [47:0] ho;
    hx = 48'(e.hdl);
    ho = 48'(o.hdl);
    r = '0;
    r.op_kind         = op;
    r.status          = ST_OK;
    r.out_prefix_addr = e.key[37:6];
    r.out_prefix_len  = e.key[5:0];
    r.out_route_id    = hx[15:0];
    r.out_ibgp        = e.ibgp;
    r.out_old_route_id = use_old ? ho[15:0] : 16'd0;
    r.out_old_ibgp    = use_old ? o.ibgp : 1'b0;
    r.group_attr_id   = ga;
    return r;
  endfunction

  state_t      state_r, state_nxt;
  in_item_t    req_r, req_nxt;
  logic        push_r, push_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic        vld_r, vld_nxt;
  logic [AW-1:0] tag_r, tag_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic        found_r, found_nxt;
  logic [AW-1:0] f_r, f_nxt;
  ent_t        fent_r, fent_nxt;
  logic        rm_b_r, rm_b_nxt;
  logic [1:0]  app_n_r, app_n_nxt;
  ent_t        app0_r, app0_nxt;
  ent_t        app1_r, app1_nxt;
  logic [15:0] attr_r, attr_nxt;
  logic        have_attr_r, have_attr_nxt;
  logic        hold_vld_r, hold_vld_nxt;
  ent_t        hold_r, hold_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  out_item_t   pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_ent;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  ent_t          rd_ent;
  ent_t          new_e;
  ent_t          old_e;
  logic          scanning;
  logic          issue;
  logic          scan_done;
  logic          tag_has_next;
  logic          f_has_next;

  rucq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_ent = ent_t'(rd_data);

  // Form the entries the request would queue
  always_comb begin
    logic [47:0] rx;
    logic [47:0] ox;
    rx = {32'd0, req_r.route_id};
    ox = {32'd0, req_r.old_route_id};
    new_e.key  = {req_r.prefix_addr, req_r.prefix_len};
    new_e.attr = req_r.attr_id;
    new_e.hdl  = rx[HANDLE_BITS-1:0];
    new_e.ibgp = req_r.from_ibgp;
    new_e.kind = K_ADD;
    old_e.key  = {req_r.prefix_addr, req_r.prefix_len};
    old_e.attr = req_r.old_attr_id;
    old_e.hdl  = ox[HANDLE_BITS-1:0];
    old_e.ibgp = req_r.old_from_ibgp;
    old_e.kind = K_OLD;
  end

  // Scan engine: one read per cycle, data tagged with its index in the cycle after the read
  assign scanning = (state_r == S_SEARCH) || (state_r == S_COMPACT) ||
                    (state_r == S_DRAIN);
  assign issue        = scanning && (rd_i_r < cnt_r);
  assign rd_addr      = rd_i_r[AW-1:0];
  assign scan_done    = (rd_i_r >= cnt_r) && !vld_r;
  assign tag_has_next = (CW'(tag_r) + CW'(1)) < cnt_r;
  assign f_has_next   = (CW'(f_r) + CW'(1)) < cnt_r;

  // Sequencer: next state, memory writes and results
  always_comb begin
    st_t         st;
    logic        rm;
    logic        rmb;
    logic [1:0]  apn;
    ent_t        a0;
    ent_t        a1;
    logic        wf1;
    logic        full;
    logic        m;
    logic        emit;
    logic [15:0] ga;
    out_item_t   res;
    out_item_t   err;

    state_nxt     = state_r;
    req_nxt       = req_r;
    push_nxt      = push_r;
    cnt_nxt       = cnt_r;
    rd_i_nxt      = issue ? rd_i_r + CW'(1) : rd_i_r;
    vld_nxt       = issue;
    tag_nxt       = rd_i_r[AW-1:0];
    w_nxt         = w_r;
    found_nxt     = found_r;
    f_nxt         = f_r;
    fent_nxt      = fent_r;
    rm_b_nxt      = rm_b_r;
    app_n_nxt     = app_n_r;
    app0_nxt      = app0_r;
    app1_nxt      = app1_r;
    attr_nxt      = attr_r;
    have_attr_nxt = have_attr_r;
    hold_vld_nxt  = hold_vld_r;
    hold_nxt      = hold_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = w_r[AW-1:0];
    wr_ent        = rd_ent;

    st   = ST_OK;
    rm   = 1'b0;
    rmb  = 1'b0;
    apn  = 2'd0;
    a0   = new_e;
    a1   = new_e;
    wf1  = 1'b0;
    full = cnt_r >= FULL_C;
    m    = 1'b0;
    emit = 1'b0;
    ga   = attr_r;
    res  = '0;
    err  = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_item;
          push_nxt = in_item.push_after || (in_item.req_type == REQ_PUSH);
          rd_i_nxt = '0;
          vld_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = (in_item.req_type == REQ_PUSH) ? S_PUSH_CHK : S_SEARCH;
        end
      end

      // Find the first entry with the request's prefix
      S_SEARCH: begin
        if (vld_r && !found_r && (rd_ent.key == new_e.key)) begin
          found_nxt = 1'b1;
          f_nxt     = tag_r;
          fent_nxt  = rd_ent;
        end
        if (scan_done) begin
          state_nxt = S_DECIDE;
        end
      end

      // Merge the request with what is queued
      S_DECIDE: begin
        case (req_r.req_type)
          REQ_ADD: begin
            if (!found_r) begin
              if (full) begin
                st = ST_FULL;
              end else begin
                apn = 2'd1;
              end
            end else if (fent_r.kind == K_ADD) begin
              st = ST_ADD_DUP;
            end else if (fent_r.kind == K_DEL) begin
              if (full) begin
                st = ST_FULL;
              end else begin
                rm      = 1'b1;
                apn     = 2'd2;
                a0      = fent_r;
                a0.kind = K_OLD;
                a1.kind = K_NEW;
              end
            end else begin
              wf1 = f_has_next;
            end
          end
          REQ_DEL: begin
            if (!found_r) begin
              if (full) begin
                st = ST_FULL;
              end else begin
                apn     = 2'd1;
                a0.kind = K_DEL;
              end
            end else if (fent_r.kind == K_ADD) begin
              rm = 1'b1;
            end else if (fent_r.kind == K_DEL) begin
              st = ST_DEL_DUP;
            end else begin
              rm      = 1'b1;
              rmb     = f_has_next;
              apn     = 2'd1;
              a0      = fent_r;
              a0.kind = K_DEL;
            end
          end
          REQ_REPLACE: begin
            if (!found_r) begin
              if (cnt_r >= NEAR_C) begin
                st = ST_FULL;
              end else begin
                apn     = 2'd2;
                a0      = old_e;
                a1.kind = K_NEW;
              end
            end else if (fent_r.kind == K_ADD) begin
              rm  = 1'b1;
              apn = 2'd1;
            end else if (fent_r.kind == K_DEL) begin
              st = ST_DEL_DUP;
            end else begin
              rm      = 1'b1;
              rmb     = f_has_next;
              apn     = 2'd2;
              a0      = fent_r;
              a0.kind = K_OLD;
              a1.kind = K_NEW;
            end
          end
          default: begin
            st = ST_OK;
          end
        endcase

        rm_b_nxt  = rmb;
        app_n_nxt = apn;
        app0_nxt  = a0;
        app1_nxt  = a1;
        if (st != ST_OK) begin
          err.op_kind   = OP_NONE;
          err.status    = st;
          err.last      = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = err;
          state_nxt     = S_IDLE;
        end else begin
          if (wf1) begin
            wr_en       = 1'b1;
            wr_addr     = f_r + AW'(1);
            wr_ent      = new_e;
            wr_ent.kind = K_NEW;
          end
          if (rm) begin
            rd_i_nxt  = '0;
            vld_nxt   = 1'b0;
            w_nxt     = '0;
            state_nxt = S_COMPACT;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end

      // Drop the matched entry (and its new half) by shifting the rest down
      S_COMPACT: begin
        if (vld_r) begin
          if (!((tag_r == f_r) || (rm_b_r && (tag_r == f_r + AW'(1))))) begin
            wr_en   = 1'b1;
            wr_addr = w_r[AW-1:0];
            wr_ent  = rd_ent;
            w_nxt   = w_r + CW'(1);
          end
        end
        if (scan_done) begin
          cnt_nxt   = w_r;
          state_nxt = S_APPEND;
        end
      end

      // Append up to two entries at the tail
      S_APPEND: begin
        if (app_n_r != 2'd0) begin
          wr_en     = 1'b1;
          wr_addr   = cnt_r[AW-1:0];
          wr_ent    = app0_r;
          cnt_nxt   = cnt_r + CW'(1);
          app0_nxt  = app1_r;
          app_n_nxt = app_n_r - 2'd1;
        end else begin
          state_nxt = S_PUSH_CHK;
        end
      end

      S_PUSH_CHK: begin
        if (push_r && (cnt_r != '0)) begin
          rd_i_nxt      = '0;
          vld_nxt       = 1'b0;
          w_nxt         = '0;
          have_attr_nxt = 1'b0;
          hold_vld_nxt  = 1'b0;
          pend_vld_nxt  = 1'b0;
          state_nxt     = S_DRAIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // One packet: emit entries of the group's attribute, compact the rest
      S_DRAIN: begin
        if (vld_r) begin
          if (hold_vld_r) begin
            m  = !have_attr_r || (rd_ent.attr == attr_r);
            ga = have_attr_r ? attr_r : rd_ent.attr;
            hold_vld_nxt = 1'b0;
            if (m) begin
              emit = 1'b1;
              res  = mk_upd(OP_REPLACE, rd_ent, hold_r, 1'b1, ga);
            end else begin
              wr_en   = 1'b1;
              wr_addr = w_r[AW-1:0] + AW'(1);
              wr_ent  = rd_ent;
              w_nxt   = w_r + CW'(2);
            end
          end else if ((rd_ent.kind == K_OLD) && tag_has_next) begin
            // Park the old half; write it ahead in case the pair is kept
            hold_nxt     = rd_ent;
            hold_vld_nxt = 1'b1;
            wr_en        = 1'b1;
            wr_addr      = w_r[AW-1:0];
            wr_ent       = rd_ent;
          end else begin
            m  = !have_attr_r || (rd_ent.attr == attr_r);
            ga = have_attr_r ? attr_r : rd_ent.attr;
            if (m) begin
              emit = 1'b1;
              res  = mk_upd((rd_ent.kind == K_DEL) ? OP_WITHDRAW : OP_ANNOUNCE,
                            rd_ent, rd_ent, 1'b0, ga);
            end else begin
              wr_en   = 1'b1;
              wr_addr = w_r[AW-1:0];
              wr_ent  = rd_ent;
              w_nxt   = w_r + CW'(1);
            end
          end
          if (!have_attr_r && !(hold_vld_nxt && !hold_vld_r)) begin
            attr_nxt      = ga;
            have_attr_nxt = 1'b1;
          end
          if (emit) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_nxt     = res;
            pend_vld_nxt = 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = S_DR_END;
        end
      end

      // Close the packet and start the next one if entries remain
      S_DR_END: begin
        out_valid_nxt       = 1'b1;
        out_nxt             = pend_r;
        out_nxt.packet_last = 1'b1;
        out_nxt.last        = (w_r == '0);
        pend_vld_nxt        = 1'b0;
        cnt_nxt             = w_r;
        if (w_r != '0) begin
          rd_i_nxt      = '0;
          vld_nxt       = 1'b0;
          w_nxt         = '0;
          have_attr_nxt = 1'b0;
          hold_vld_nxt  = 1'b0;
          state_nxt     = S_DRAIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      have_attr_r <= 1'b0;
      found_r     <= 1'b0;
      rd_i_r      <= '0;
      w_r         <= '0;
      app_n_r     <= 2'd0;
      push_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
      hold_vld_r  <= hold_vld_nxt;
      have_attr_r <= have_attr_nxt;
      found_r     <= found_nxt;
      rd_i_r      <= rd_i_nxt;
      w_r         <= w_nxt;
      app_n_r     <= app_n_nxt;
      push_r      <= push_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    tag_r    <= tag_nxt;
    f_r      <= f_nxt;
    fent_r   <= fent_nxt;
    rm_b_r   <= rm_b_nxt;
    app0_r   <= app0_nxt;
    app1_r   <= app1_nxt;
    attr_r   <= attr_nxt;
    hold_r   <= hold_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// File: design/rucq_checker.sv
`default_nettype none
`include "route_update_coalescing_queue_defines.svh"
module rucq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire rucq_pkg::out_item_t out_item
);
  import rucq_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  `RUCQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy did not rise after accept")

  // An error result stands alone and ends its request
  `RUCQ_ASSERT_NOW(a_err_is_last, out_valid && (out_item.status != ST_OK), (out_item.op_kind == OP_NONE) && out_item.last, "error result malformed")

  // The last result of a request closes a packet unless it is an error
  `RUCQ_ASSERT_NOW(a_last_closes_packet, out_valid && out_item.last && (out_item.op_kind != OP_NONE), out_item.packet_last, "last result not packet_last")

  // No result follows the last one of a request in the next cycle
  `RUCQ_ASSERT_NEXT(a_gap_after_last, out_valid && out_item.last, !out_valid, "result right after last")

endmodule

bind route_update_coalescing_queue rucq_checker u_rucq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
